// ----- hdl/kbc_pkg.sv -----
// ----------------------------------------------------------------------------
// kbc_pkg
// Shared types, constants and round functions of the 32/64 block cipher.
// ----------------------------------------------------------------------------
package kbc_pkg;

   localparam int unsigned BLOCK_W     = 32;
   localparam int unsigned KEY_W       = 64;
   localparam int unsigned ROUNDS_PER_STAGE = 8;

   localparam logic [31:0] NLF_TABLE = 32'h3A5C742E;

   // register index, taken from csr_paddr[3]
   localparam logic REG_CIPHER_KEY = 1'b0;

   typedef enum logic {
      MODE_ENCRYPT = 1'b0,
      MODE_DECRYPT = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic [BLOCK_W-1:0]   block;
   } item_type;

   function automatic logic [BLOCK_W-1:0] enc_round(input logic [BLOCK_W-1:0] x,
                                                    input logic kb);
      logic [4:0] idx;
      logic       fb;
      idx = {x[31], x[26], x[20], x[9], x[1]};
      fb  = NLF_TABLE[idx] ^ x[0] ^ x[16] ^ kb;
      return {fb, x[BLOCK_W-1:1]};
   endfunction

   function automatic logic [BLOCK_W-1:0] dec_round(input logic [BLOCK_W-1:0] x,
                                                    input logic kb);
      logic [4:0] idx;
      logic       fb;
      idx = {x[30], x[25], x[19], x[8], x[0]};
      fb  = NLF_TABLE[idx] ^ x[31] ^ x[15] ^ kb;
      return {x[BLOCK_W-2:0], fb};
   endfunction

endpackage

// ----- hdl/kbc_csr.sv -----
// ----------------------------------------------------------------------------
// kbc_csr
// Register port holding the 64-bit cipher key.
// ----------------------------------------------------------------------------
module kbc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [3:0]                  csr_paddr,
   input  logic [kbc_pkg::KEY_W-1:0]   csr_pwdata,
   output logic [kbc_pkg::KEY_W-1:0]   csr_prdata,
   output logic                        csr_pready,
   output logic [kbc_pkg::KEY_W-1:0]   cipher_key
);
   import kbc_pkg::*;

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic             key_sel;

   assign key_sel    = (csr_paddr[3] == REG_CIPHER_KEY);
   assign csr_pready = 1'b1;

   always_comb begin
      key_in = key_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && key_sel) begin
         key_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign csr_prdata = key_sel ? key_ff : '0;
   assign cipher_key = key_ff;

endmodule

// ----- hdl/kbc_round_stage.sv -----
// ----------------------------------------------------------------------------
// kbc_round_stage
// One pipeline stage: a short run of encrypt or decrypt rounds, registered.
// ----------------------------------------------------------------------------
module kbc_round_stage #(
   parameter int unsigned ROUND_COUNT = 528,
   parameter int unsigned FIRST_STEP  = 0,
   parameter int unsigned STEPS       = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        valid_in,
   input  kbc_pkg::item_type           item_in,
   input  logic [kbc_pkg::KEY_W-1:0]   cipher_key,
   output logic                        valid_out,
   output kbc_pkg::item_type           item_out
);
   import kbc_pkg::*;

   logic     valid_ff;
   logic     valid_in_next;
   item_type item_ff;
   item_type item_in_next;

   // step j uses key bit j mod 64 going forward, key bit (ROUND_COUNT-1-j) mod 64 going back
   always_comb begin
      logic [BLOCK_W-1:0] x;
      x = item_in.block;
      for (int unsigned k = 0; k < STEPS; k++) begin
         if (item_in.mode == MODE_DECRYPT) begin
            x = dec_round(x, cipher_key[6'(ROUND_COUNT - 1 - FIRST_STEP - k)]);
         end else begin
            x = enc_round(x, cipher_key[6'(FIRST_STEP + k)]);
         end
      end
      item_in_next.mode  = item_in.mode;
      item_in_next.block = x;
   end

   assign valid_in_next = advance ? valid_in : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign item_out  = item_ff;

endmodule

// ----- hdl/kbc_out_buf.sv -----
// ----------------------------------------------------------------------------
// kbc_out_buf
// Output register with skid entry; holds the pipeline while it is full.
// ----------------------------------------------------------------------------
module kbc_out_buf (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_in,
   input  logic [kbc_pkg::BLOCK_W-1:0]   block_in,
   output logic                          advance,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [kbc_pkg::BLOCK_W-1:0]   rsp_tdata
);
   import kbc_pkg::*;

   logic               out_valid_ff, out_valid_in;
   logic [BLOCK_W-1:0] out_data_ff, out_data_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [BLOCK_W-1:0] skid_data_ff, skid_data_in;
   logic               push;
   logic               pop;

   assign advance = !skid_valid_ff;
   assign push    = advance && valid_in;
   assign pop     = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = block_in;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = block_in;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ----- hdl/keeloq_block_cipher.sv -----
// ----------------------------------------------------------------------------
// keeloq_block_cipher
// Pipelined 32-bit block cipher with 64-bit key, encrypt or decrypt per block.
//
//   port group | direction | contents
//   req_       | in        | tdata = block_in[31:0], tuser = mode
//   rsp_       | out       | tdata = block_out[31:0]
//   csr_       | in/out    | key at byte address 0, 64-bit data
//
// One block per cycle unless the output buffer holds the pipeline; 8 rounds per
// stage, then the output register.
// Reset clears the stage valid bits, the output buffer and the key.
// A stalled output fills the skid entry, then freezes every stage together.
// ----------------------------------------------------------------------------
module keeloq_block_cipher #(
   parameter int unsigned ROUND_COUNT = 528
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [kbc_pkg::BLOCK_W-1:0]   req_tdata,   // [31:0] block_in
   input  logic                          req_tuser,   // [0] mode
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [kbc_pkg::BLOCK_W-1:0]   rsp_tdata,   // [31:0] block_out
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [3:0]                    csr_paddr,
   input  logic [kbc_pkg::KEY_W-1:0]     csr_pwdata,
   output logic [kbc_pkg::KEY_W-1:0]     csr_prdata,
   output logic                          csr_pready
);
   import kbc_pkg::*;

   localparam int unsigned NSTAGE = (ROUND_COUNT + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;

   logic [KEY_W-1:0] cipher_key;
   logic             advance;
   logic             valid_s [NSTAGE+1];
   item_type         item_s  [NSTAGE+1];

   kbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cipher_key  (cipher_key)
   );

   assign req_tready      = advance;
   assign valid_s[0]      = req_tvalid;
   assign item_s[0].mode  = mode_type'(req_tuser);
   assign item_s[0].block = req_tdata;

   for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
      localparam int unsigned FIRST = s * ROUNDS_PER_STAGE;
      localparam int unsigned STEPS = (ROUND_COUNT - FIRST < ROUNDS_PER_STAGE) ?
                                      (ROUND_COUNT - FIRST) : ROUNDS_PER_STAGE;
      kbc_round_stage #(
         .ROUND_COUNT (ROUND_COUNT),
         .FIRST_STEP  (FIRST),
         .STEPS       (STEPS)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .valid_in   (valid_s[s]),
         .item_in    (item_s[s]),
         .cipher_key (cipher_key),
         .valid_out  (valid_s[s+1]),
         .item_out   (item_s[s+1])
      );
   end

   kbc_out_buf u_out (
      .clock      (clock),
      .reset      (reset),
      .valid_in   (valid_s[NSTAGE]),
      .block_in   (item_s[NSTAGE].block),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- hdl/kbc_checker.sv -----
// ----------------------------------------------------------------------------
// kbc_checker
// Port-level checks on the cipher block, bound to the top level.
// ----------------------------------------------------------------------------
module kbc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [kbc_pkg::BLOCK_W-1:0]   rsp_tdata,
   input logic                          csr_psel,
   input logic                          csr_penable,
   input logic                          csr_pwrite,
   input logic [3:0]                    csr_paddr,
   input logic [kbc_pkg::KEY_W-1:0]     csr_pwdata,
   input logic [kbc_pkg::KEY_W-1:0]     csr_prdata,
   input logic                          csr_pready
);
   import kbc_pkg::*;

   logic key_write;
   logic key_read;
   assign key_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[3] == REG_CIPHER_KEY);
   assign key_read  = csr_psel && !csr_pwrite && (csr_paddr[3] == REG_CIPHER_KEY);

   // nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // a held result keeps its data
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result data changed while stalled");

   // key read-back reflects the last transfer
   a_key_readback: assert property (@(posedge clock) disable iff (reset)
      key_write ##1 key_read |-> csr_prdata == $past(csr_pwdata))
      else $error("key read-back mismatch");

endmodule

bind keeloq_block_cipher kbc_checker u_kbc_checker (.*);

// ----- tb/keeloq_block_cipher_tb.sv -----
// ----------------------------------------------------------------------------
// keeloq_block_cipher_tb
// Self-checking testbench for the pipelined 32/64 block cipher.
//
// Blocks to encipher or decipher are queued by a sequencer and sent by a
// clocked driver. The driver works out each expected word at the transfer,
// using a bit-serial model of the 528 rounds under a shadow copy of the key.
// A clocked monitor checks every result in order. The key is changed over APB
// only while the pipeline is empty. The idle patterns on both streams vary
// by phase, and one long output stall backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module keeloq_block_cipher_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import kbc_pkg::*;

   localparam int unsigned ROUNDS      = 528;
   localparam logic [31:0] NLF_CODE    = 32'h3A5C742E;
   localparam logic [3:0]  KEY_ADDR    = 4'd0;
   localparam logic [3:0]  SPARE_ADDR  = 4'd8;
   localparam int          LONG_HOLD   = 400;
   localparam int          DRAIN_WAIT  = 80;
   localparam int          CYCLE_LIMIT = 200000;

   typedef struct {
      mode_type    mode;
      logic [31:0] word;
   } cipher_job_type;

   typedef struct {
      mode_type    mode;
      logic [31:0] word_in;
      logic [31:0] word_out;
   } cipher_result_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // [31:0] block_in
   logic        req_tuser   = 1'b0; // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] block_out
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [63:0] csr_pwdata  = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   cipher_job_type    job_queue[$];
   cipher_result_type awaited_words[$];
   logic [63:0]    key_shadow    = '0;
   int             send_idle_pct = 12;
   int             recv_idle_pct = 71;
   int             long_stall_ask  = 0;
   int             long_stall_done = 0;
   int             hold_left     = 0;
   int             error_count   = 0;
   int             encipher_count = 0;
   int             decipher_count = 0;
   int             checked_count = 0;
   int             key_settings  = 1;

   keeloq_block_cipher #(.ROUND_COUNT(ROUNDS)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] keeloq_encipher(input logic [31:0] plain,
                                                   input logic [63:0] key);
      logic [31:0] x;
      logic [4:0]  idx;
      logic        fb;
      x = plain;
      for (int r = 0; r < ROUNDS; r++) begin
         idx = {x[31], x[26], x[20], x[9], x[1]};
         fb  = NLF_CODE[idx] ^ x[0] ^ x[16] ^ key[r % 64];
         x   = {fb, x[31:1]};
      end
      return x;
   endfunction

   function automatic logic [31:0] keeloq_decipher(input logic [31:0] cipher,
                                                   input logic [63:0] key);
      logic [31:0] x;
      logic [4:0]  idx;
      logic        fb;
      x = cipher;
      for (int r = ROUNDS - 1; r >= 0; r--) begin
         idx = {x[30], x[25], x[19], x[8], x[0]};
         fb  = NLF_CODE[idx] ^ x[31] ^ x[15] ^ key[r % 64];
         x   = {x[30:0], fb};
      end
      return x;
   endfunction

   // driver: one new block whenever the slot is free and the sender is not idling
   always @(posedge clock) begin
      cipher_result_type res;
      cipher_job_type    job;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            res.mode    = mode_type'(req_tuser);
            res.word_in = req_tdata;
            if (res.mode == MODE_DECRYPT) begin
               res.word_out = keeloq_decipher(req_tdata, key_shadow);
               decipher_count++;
            end else begin
               res.word_out = keeloq_encipher(req_tdata, key_shadow);
               encipher_count++;
            end
            awaited_words.push_back(res);
         end
         if (!req_tvalid || req_tready) begin
            if (job_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               job = job_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= job.word;
               req_tuser  <= job.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      cipher_result_type res;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_words.size() == 0) begin
               $display("%0t: unexpected result, actual 0x%08h", $time, rsp_tdata);
               error_count++;
            end else begin
               res = awaited_words.pop_front();
               checked_count++;
               if (rsp_tdata !== res.word_out) begin
                  $display("%0t: block_out mismatch (%s 0x%08h) expected 0x%08h actual 0x%08h",
                           $time, (res.mode == MODE_DECRYPT) ? "decrypt" : "encrypt",
                           res.word_in, res.word_out, rsp_tdata);
                  error_count++;
               end
            end
         end
         if (long_stall_done != long_stall_ask) begin
            long_stall_done = long_stall_ask;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic csr_write(input logic [3:0] addr, input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == KEY_ADDR) begin
         key_shadow = value;
      end
   endtask

   task automatic check_key_readback();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= KEY_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== key_shadow) begin
         $display("%0t: cipher_key readback mismatch expected 0x%016h actual 0x%016h",
                  $time, key_shadow, csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_key(input logic [63:0] value);
      csr_write(KEY_ADDR, value);
      key_settings++;
      check_key_readback();
   endtask

   task automatic push_job(input mode_type mode, input logic [31:0] word);
      cipher_job_type job;
      job.mode = mode;
      job.word = word;
      job_queue.push_back(job);
   endtask

   // encipher a word, then decipher the ciphertext back
   task automatic push_round_trip(input logic [31:0] plain);
      push_job(MODE_ENCRYPT, plain);
      push_job(MODE_DECRYPT, keeloq_encipher(plain, key_shadow));
   endtask

   task automatic queue_random_jobs(input int count);
      for (int i = 0; i < count; i++) begin
         push_job(mode_type'($urandom_range(1)), $urandom);
      end
   endtask

   task automatic wait_drained();
      while (job_queue.size() != 0 || awaited_words.size() != 0 || req_tvalid) begin
         @(posedge clock);
      end
   endtask

   initial begin : sequencer
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      check_key_readback();

      // key still at its reset value
      push_job(MODE_ENCRYPT, 32'h0000_0000);
      push_job(MODE_ENCRYPT, 32'hFFFF_FFFF);
      push_job(MODE_DECRYPT, 32'h0000_0000);
      push_job(MODE_DECRYPT, 32'hFFFF_FFFF);
      wait_drained();

      program_key({$urandom, $urandom});
      // write to an unmapped register must leave the key alone
      csr_write(SPARE_ADDR, ~key_shadow);
      check_key_readback();
      push_job(MODE_ENCRYPT, 32'h8000_0001);
      push_job(MODE_DECRYPT, 32'h8000_0001);
      push_job(MODE_ENCRYPT, 32'h5555_5555);
      push_job(MODE_ENCRYPT, 32'hAAAA_AAAA);
      push_job(MODE_DECRYPT, 32'h7FFF_FFFE);
      for (int i = 0; i < 4; i++) begin
         push_round_trip($urandom);
      end
      wait_drained();

      program_key('1);
      push_job(MODE_ENCRYPT, 32'h0000_0000);
      push_job(MODE_DECRYPT, 32'hFFFF_FFFF);
      push_round_trip($urandom);
      wait_drained();

      program_key({$urandom, $urandom});
      queue_random_jobs(450);
      wait_drained();

      send_idle_pct = 71;
      recv_idle_pct = 12;
      program_key(64'h8000_0000_0000_0001);
      queue_random_jobs(450);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_key({$urandom, $urandom});
      queue_random_jobs(250);
      long_stall_ask++;
      wait_drained();
      queue_random_jobs(200);
      wait_drained();

      repeat (DRAIN_WAIT) @(posedge clock);
      $display("summary: %0d enciphered and %0d deciphered blocks, %0d results checked",
               encipher_count, decipher_count, checked_count);
      $display("summary: %0d key settings incl. zero and all-ones, one long output stall",
               key_settings);
      if (error_count == 0 && awaited_words.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/kbc_pkg.sv
hdl/kbc_csr.sv
hdl/kbc_round_stage.sv
hdl/kbc_out_buf.sv
hdl/keeloq_block_cipher.sv
hdl/kbc_checker.sv
tb/keeloq_block_cipher_tb.sv
